@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, disabled while reset is asserted.
`define TPSD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tpsd assertion failed");

// Concurrent assertion, checked during reset too.
`define TPSD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tpsd assertion failed");

`endif

@@ sv/tpsd_pkg.sv @@
// Types and constants of the tape pulse sync and byte decoder.
`default_nettype none
package tpsd_pkg;

  localparam logic [1:0] PC_ZERO = 2'd0;
  localparam logic [1:0] PC_ONE  = 2'd1;

  localparam logic [1:0] EV_DATA  = 2'd0;
  localparam logic [1:0] EV_SYNC  = 2'd1;
  localparam logic [1:0] EV_CHECK = 2'd2;
  localparam logic [1:0] EV_ABORT = 2'd3;

  localparam logic [1:0] PM_NONE  = 2'd0;
  localparam logic [1:0] PM_BYTE  = 2'd1;
  localparam logic [1:0] PM_ONES  = 2'd2;
  localparam logic [1:0] PM_ZEROS = 2'd3;

  localparam logic [2:0] CM_NONE      = 3'd0;
  localparam logic [2:0] CM_ADD       = 3'd1;
  localparam logic [2:0] CM_XOR       = 3'd2;
  localparam logic [2:0] CM_ADD_CHECK = 3'd3;
  localparam logic [2:0] CM_XOR_CHECK = 3'd4;

  localparam logic [2:0] CFG_BIT_ORDER       = 3'd0;
  localparam logic [2:0] CFG_PILOT_MODE      = 3'd1;
  localparam logic [2:0] CFG_PILOT_VALUE     = 3'd2;
  localparam logic [2:0] CFG_MIN_PILOT_COUNT = 3'd3;
  localparam logic [2:0] CFG_SYNC_LENGTH     = 3'd4;
  localparam logic [2:0] CFG_SYNC_BYTES      = 3'd5;
  localparam logic [2:0] CFG_CHECKSUM_MODE   = 3'd6;
  localparam logic [2:0] CFG_DATA_LENGTH     = 3'd7;

  localparam logic [3:0]  PILOT_LOCK_MATCHES = 4'd8;
  localparam logic [15:0] RUN_COUNT_MAX      = 16'hFFFF;

  typedef struct packed {
    logic        bit_order;
    logic [1:0]  pilot_mode;
    logic [7:0]  pilot_value;
    logic [15:0] min_pilot_count;
    logic [3:0]  sync_length;
    logic [63:0] sync_bytes;
    logic [2:0]  checksum_mode;
    logic [15:0] data_length;
  } cfg_t;

  typedef struct packed {
    logic inv;
    logic val;
  } tok_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [7:0]  data_value;
    logic [15:0] byte_index;
    logic [7:0]  running_checksum;
    logic        checksum_ok;
    logic        block_last;
  } result_t;

  typedef enum logic [4:0] {
    PH_HUNT        = 5'b00001,
    PH_PILOT_BYTES = 5'b00010,
    PH_SYNC        = 5'b00100,
    PH_DATA        = 5'b01000,
    PH_CHECK       = 5'b10000
  } phase_t;

endpackage
`default_nettype wire

@@ sv/tape_pulse_sync_and_byte_decoder_unit.sv @@
// Top level of the tape pulse sync and byte decoder.
// Input channel: in_valid/in_ready with in_pulse_class, one classified pulse
//   per transfer (0 zero bit, 1 one bit, 2 or 3 invalid).
// Output channel: out_valid/out_ready with event kind, byte, index, checksum,
//   checksum match and block end flag; at most one result per pulse.
// Configuration: cfg_we writes cfg_wdata into register cfg_index (0 bit order,
//   1 pilot mode, 2 pilot byte, 3 minimum pilot count, 4 sync length,
//   5 sync bytes, 6 checksum mode, 7 data length); write only while idle.
// Throughput: one pulse per cycle unless a waiting result holds the decoder.
// Path: a pulse passes through the token queue and then the result register
//   before its result can be transferred.
// Stall: while a result waits, the decoder holds; pulses keep filling the
//   token queue and in_ready drops once it is full.
// Reset: rst_n (synchronous, active low) empties the queue and result
//   register, restarts the pilot search and loads the register defaults.
`default_nettype none
module tape_pulse_sync_and_byte_decoder_unit #(
  parameter int MAX_SYNC_BYTES = 8,
  parameter int QUEUE_DEPTH    = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_pulse_class,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_event_kind,
  output logic [7:0]       out_data_value,
  output logic [15:0]      out_byte_index,
  output logic [7:0]       out_running_checksum,
  output logic             out_checksum_ok,
  output logic             out_block_last,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_wdata
);

  tpsd_pkg::cfg_t    cfg_r;
  tpsd_pkg::tok_t    push_tok, head_tok;
  tpsd_pkg::result_t res;
  logic              q_full, q_push, q_pop, q_not_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bit_order       <= 1'b0;
      cfg_r.pilot_mode      <= tpsd_pkg::PM_BYTE;
      cfg_r.pilot_value     <= '0;
      cfg_r.min_pilot_count <= '0;
      cfg_r.sync_length     <= '0;
      cfg_r.sync_bytes      <= '0;
      cfg_r.checksum_mode   <= tpsd_pkg::CM_NONE;
      cfg_r.data_length     <= 16'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tpsd_pkg::CFG_BIT_ORDER:       cfg_r.bit_order       <= cfg_wdata[0];
        tpsd_pkg::CFG_PILOT_MODE:      cfg_r.pilot_mode      <= cfg_wdata[1:0];
        tpsd_pkg::CFG_PILOT_VALUE:     cfg_r.pilot_value     <= cfg_wdata[7:0];
        tpsd_pkg::CFG_MIN_PILOT_COUNT: cfg_r.min_pilot_count <= cfg_wdata[15:0];
        tpsd_pkg::CFG_SYNC_LENGTH:     cfg_r.sync_length     <= cfg_wdata[3:0];
        tpsd_pkg::CFG_SYNC_BYTES:      cfg_r.sync_bytes      <= cfg_wdata;
        tpsd_pkg::CFG_CHECKSUM_MODE:   cfg_r.checksum_mode   <= cfg_wdata[2:0];
        tpsd_pkg::CFG_DATA_LENGTH:     cfg_r.data_length     <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  tpsd_front u_front (
    .in_valid       (in_valid),
    .in_pulse_class (in_pulse_class),
    .in_ready       (in_ready),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_tok          (push_tok)
  );

  tpsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_tok  (push_tok),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_tok  (head_tok)
  );

  tpsd_back #(
    .MAX_SYNC_BYTES (MAX_SYNC_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .tok_valid (q_not_empty),
    .tok       (head_tok),
    .tok_pop   (q_pop),
    .res_valid (out_valid),
    .res_ready (out_ready),
    .res       (res)
  );

  assign out_event_kind       = res.event_kind;
  assign out_data_value       = res.data_value;
  assign out_byte_index       = res.byte_index;
  assign out_running_checksum = res.running_checksum;
  assign out_checksum_ok      = res.checksum_ok;
  assign out_block_last       = res.block_last;

endmodule
`default_nettype wire

@@ sv/tpsd_front.sv @@
// Front end: accepts pulses and classifies them into bit tokens.
`default_nettype none
module tpsd_front (
  input  wire logic          in_valid,
  input  wire logic [1:0]    in_pulse_class,
  output logic               in_ready,
  input  wire logic          q_full,
  output logic               q_push,
  output tpsd_pkg::tok_t     q_tok
);

  assign in_ready  = !q_full;
  assign q_push    = in_valid && !q_full;
  assign q_tok.inv = (in_pulse_class != tpsd_pkg::PC_ZERO) &&
                     (in_pulse_class != tpsd_pkg::PC_ONE);
  assign q_tok.val = (in_pulse_class == tpsd_pkg::PC_ONE);

endmodule
`default_nettype wire

@@ sv/tpsd_queue.sv @@
// Small token queue between the front end and the decoder.
`default_nettype none
module tpsd_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire tpsd_pkg::tok_t push_tok,
  output logic                full,
  input  wire logic           pop,
  output logic                not_empty,
  output tpsd_pkg::tok_t      head_tok
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  tpsd_pkg::tok_t mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign full      = (cnt_r == FULL_CNT);
  assign not_empty = (cnt_r != '0);
  assign head_tok  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

endmodule
`default_nettype wire

@@ sv/tpsd_back.sv @@
// Back end: pilot, sync, data and checksum decoding with a result register.
`default_nettype none
module tpsd_back #(
  parameter int MAX_SYNC_BYTES = 8
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire tpsd_pkg::cfg_t cfg,
  input  wire logic           tok_valid,
  input  wire tpsd_pkg::tok_t tok,
  output logic                tok_pop,
  output logic                res_valid,
  input  wire logic           res_ready,
  output tpsd_pkg::result_t   res
);

  localparam logic [3:0] MAX_SYNC = 4'(MAX_SYNC_BYTES);

  tpsd_pkg::phase_t  phase_r, phase_nxt;
  logic [7:0]        sb_r, sb_nxt;
  logic [2:0]        bc_r, bc_nxt;
  logic [3:0]        mc_r, mc_nxt;
  logic [15:0]       rc_r, rc_nxt;
  logic [3:0]        si_r, si_nxt;
  logic [7:0]        cs_r, cs_nxt;
  logic [15:0]       dc_r, dc_nxt;
  logic              ov_r, ov_nxt;
  tpsd_pkg::result_t res_r, res_nxt;

  logic [3:0]  sync_len;
  logic [15:0] data_len;
  logic        checked;

  assign sync_len = (cfg.sync_length > MAX_SYNC) ? MAX_SYNC : cfg.sync_length;
  assign data_len = (cfg.data_length == '0) ? 16'd1 : cfg.data_length;
  assign checked  = (cfg.checksum_mode == tpsd_pkg::CM_ADD_CHECK) ||
                    (cfg.checksum_mode == tpsd_pkg::CM_XOR_CHECK);

  assign tok_pop   = tok_valid && (!ov_r || res_ready);
  assign res_valid = ov_r;
  assign res       = res_r;

  always_comb begin
    tpsd_pkg::phase_t ph;
    logic [7:0]  sh;
    logic [7:0]  want;
    logic [15:0] idx;
    logic        do_restart;
    logic        do_enter;
    logic        do_match;
    logic        emit;
    logic        done;
    logic        pilot_bit;
    phase_nxt  = phase_r;
    sb_nxt     = sb_r;
    bc_nxt     = bc_r;
    mc_nxt     = mc_r;
    rc_nxt     = rc_r;
    si_nxt     = si_r;
    cs_nxt     = cs_r;
    dc_nxt     = dc_r;
    ov_nxt     = ov_r && !res_ready;
    res_nxt    = res_r;
    ph         = phase_r;
    sh         = sb_r;
    do_restart = 1'b0;
    do_enter   = 1'b0;
    do_match   = 1'b0;
    emit       = 1'b0;
    done       = 1'b0;
    want       = '0;
    idx        = '0;
    pilot_bit  = (cfg.pilot_mode == tpsd_pkg::PM_ZEROS);

    if (tok_pop) begin
      ph = phase_r;
      if (ph == tpsd_pkg::PH_HUNT &&
          (cfg.pilot_mode == tpsd_pkg::PM_NONE || cfg.pilot_mode == tpsd_pkg::PM_BYTE) &&
          sync_len == '0) begin
        ph     = tpsd_pkg::PH_DATA;
        bc_nxt = '0;
        cs_nxt = '0;
        dc_nxt = '0;
      end else if (ph == tpsd_pkg::PH_HUNT && cfg.pilot_mode == tpsd_pkg::PM_NONE) begin
        ph = tpsd_pkg::PH_SYNC;
      end
      phase_nxt = ph;
      sh = cfg.bit_order ? {sb_r[6:0], tok.val} : {tok.val, sb_r[7:1]};

      if (tok.inv) begin
        if (ph == tpsd_pkg::PH_DATA || ph == tpsd_pkg::PH_CHECK) begin
          emit    = 1'b1;
          res_nxt = '{tpsd_pkg::EV_ABORT, 8'd0, dc_nxt, cs_nxt, 1'b0, 1'b1};
        end
        do_restart = 1'b1;
      end else begin
        unique case (ph)
          tpsd_pkg::PH_HUNT: begin
            if (cfg.pilot_mode == tpsd_pkg::PM_BYTE) begin
              sb_nxt = sh;
              if (sh == cfg.pilot_value) begin
                mc_nxt = mc_r + 4'd1;
                if (mc_nxt >= tpsd_pkg::PILOT_LOCK_MATCHES) begin
                  mc_nxt    = tpsd_pkg::PILOT_LOCK_MATCHES;
                  phase_nxt = tpsd_pkg::PH_PILOT_BYTES;
                  bc_nxt    = '0;
                  rc_nxt    = '0;
                end
              end
            end else if (tok.val != pilot_bit) begin
              if (rc_r != tpsd_pkg::RUN_COUNT_MAX) begin
                rc_nxt = rc_r + 16'd1;
              end
            end else if (rc_r < cfg.min_pilot_count) begin
              do_restart = 1'b1;
            end else begin
              si_nxt = '0;
              if (sync_len == '0) begin
                emit     = 1'b1;
                res_nxt  = '{tpsd_pkg::EV_SYNC, 8'd0, 16'd0, 8'd0, 1'b0, 1'b0};
                do_enter = 1'b1;
              end else begin
                phase_nxt = tpsd_pkg::PH_SYNC;
                bc_nxt    = '0;
                sb_nxt    = '0;
              end
            end
          end
          tpsd_pkg::PH_PILOT_BYTES: begin
            sb_nxt = sh;
            if (bc_r != 3'd7) begin
              bc_nxt = bc_r + 3'd1;
            end else begin
              bc_nxt = '0;
              if (rc_r != tpsd_pkg::RUN_COUNT_MAX) begin
                rc_nxt = rc_r + 16'd1;
              end
              if (sh != cfg.pilot_value) begin
                if (rc_nxt < cfg.min_pilot_count) begin
                  phase_nxt = tpsd_pkg::PH_HUNT;
                  mc_nxt    = '0;
                  rc_nxt    = '0;
                end else begin
                  si_nxt   = '0;
                  do_match = 1'b1;
                end
              end
            end
          end
          tpsd_pkg::PH_SYNC: begin
            sb_nxt = sh;
            if (bc_r != 3'd7) begin
              bc_nxt = bc_r + 3'd1;
            end else begin
              bc_nxt   = '0;
              do_match = 1'b1;
            end
          end
          tpsd_pkg::PH_DATA: begin
            sb_nxt = sh;
            if (bc_r != 3'd7) begin
              bc_nxt = bc_r + 3'd1;
            end else begin
              bc_nxt = '0;
              if (cfg.checksum_mode == tpsd_pkg::CM_ADD ||
                  cfg.checksum_mode == tpsd_pkg::CM_ADD_CHECK) begin
                cs_nxt = cs_nxt + sh;
              end else if (cfg.checksum_mode == tpsd_pkg::CM_XOR ||
                           cfg.checksum_mode == tpsd_pkg::CM_XOR_CHECK) begin
                cs_nxt = cs_nxt ^ sh;
              end
              idx    = dc_nxt;
              dc_nxt = dc_nxt + 16'd1;
              done   = ({1'b0, idx} + 17'd1) >= {1'b0, data_len};
              emit   = 1'b1;
              res_nxt = '{tpsd_pkg::EV_DATA, sh, idx, cs_nxt, 1'b0, done && !checked};
              if (done) begin
                if (checked) begin
                  phase_nxt = tpsd_pkg::PH_CHECK;
                  bc_nxt    = '0;
                end else begin
                  do_restart = 1'b1;
                end
              end
            end
          end
          tpsd_pkg::PH_CHECK: begin
            sb_nxt = sh;
            if (bc_r != 3'd7) begin
              bc_nxt = bc_r + 3'd1;
            end else begin
              emit       = 1'b1;
              res_nxt    = '{tpsd_pkg::EV_CHECK, sh, dc_r, cs_r, sh == cs_r, 1'b1};
              do_restart = 1'b1;
            end
          end
          default: begin
            do_restart = 1'b1;
          end
        endcase

        if (do_match) begin
          if (sync_len != '0) begin
            want = cfg.sync_bytes[{si_nxt[2:0], 3'b000} +: 8];
            if (sh != want) begin
              do_restart = 1'b1;
            end else begin
              si_nxt = {1'b0, si_nxt[2:0]} + 4'd1;
              if (si_nxt < sync_len) begin
                phase_nxt = tpsd_pkg::PH_SYNC;
                bc_nxt    = '0;
              end
            end
          end
          if (!do_restart && (sync_len == '0 || si_nxt >= sync_len)) begin
            emit     = 1'b1;
            res_nxt  = '{tpsd_pkg::EV_SYNC, sh, 16'd0, 8'd0, 1'b0, 1'b0};
            do_enter = 1'b1;
          end
        end
      end

      if (do_enter) begin
        phase_nxt = tpsd_pkg::PH_DATA;
        bc_nxt    = '0;
        cs_nxt    = '0;
        dc_nxt    = '0;
      end
      if (do_restart) begin
        phase_nxt = tpsd_pkg::PH_HUNT;
        sb_nxt    = '0;
        bc_nxt    = '0;
        mc_nxt    = '0;
        rc_nxt    = '0;
        si_nxt    = '0;
        cs_nxt    = '0;
        dc_nxt    = '0;
      end
      if (emit) begin
        ov_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= tpsd_pkg::PH_HUNT;
      sb_r    <= '0;
      bc_r    <= '0;
      mc_r    <= '0;
      rc_r    <= '0;
      si_r    <= '0;
      cs_r    <= '0;
      dc_r    <= '0;
      ov_r    <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      sb_r    <= sb_nxt;
      bc_r    <= bc_nxt;
      mc_r    <= mc_nxt;
      rc_r    <= rc_nxt;
      si_r    <= si_nxt;
      cs_r    <= cs_nxt;
      dc_r    <= dc_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule
`default_nettype wire

@@ sv/tpsd_checker.sv @@
// Port-level checker for the tape pulse sync and byte decoder, with its bind.
`default_nettype none
`include "assert_macros.svh"
module tpsd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_event_kind,
  input wire logic [7:0]  out_data_value,
  input wire logic [15:0] out_byte_index,
  input wire logic [7:0]  out_running_checksum,
  input wire logic        out_checksum_ok,
  input wire logic        out_block_last
);

  `TPSD_ASSERT_ALWAYS(a_reset_clears_out, clk, !rst_n |=> !out_valid)

  `TPSD_ASSERT(a_out_hold, clk, rst_n,
    (out_valid && !out_ready) |=> (out_valid && $stable(out_event_kind) &&
    $stable(out_data_value) && $stable(out_byte_index)))

  `TPSD_ASSERT(a_sync_fields, clk, rst_n,
    (out_valid && out_event_kind == tpsd_pkg::EV_SYNC) |-> (out_byte_index == 16'd0 &&
    out_running_checksum == 8'd0 && !out_checksum_ok && !out_block_last))

  `TPSD_ASSERT(a_abort_fields, clk, rst_n,
    (out_valid && out_event_kind == tpsd_pkg::EV_ABORT) |->
    (out_block_last && out_data_value == 8'd0 && !out_checksum_ok))

  `TPSD_ASSERT(a_check_last, clk, rst_n,
    (out_valid && out_checksum_ok) |->
    (out_event_kind == tpsd_pkg::EV_CHECK && out_block_last))

endmodule

bind tape_pulse_sync_and_byte_decoder_unit tpsd_checker u_tpsd_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_event_kind       (out_event_kind),
  .out_data_value       (out_data_value),
  .out_byte_index       (out_byte_index),
  .out_running_checksum (out_running_checksum),
  .out_checksum_ok      (out_checksum_ok),
  .out_block_last       (out_block_last)
);
`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the tape pulse sync and byte decoder unit.
`timescale 1ns / 100ps
module tb_top;

  localparam int          SYNC_MAX      = 8;
  localparam int          PULSE_TARGET  = 1850;
  localparam int          CYCLE_LIMIT   = 1000000;
  localparam logic [1:0]  PC_INVALID    = 2'd2;
  localparam logic [1:0]  PC_INVALID_HI = 2'd3;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_pulse_class = tpsd_pkg::PC_ZERO;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_event_kind;
  logic [7:0]  out_data_value;
  logic [15:0] out_byte_index;
  logic [7:0]  out_running_checksum;
  logic        out_checksum_ok;
  logic        out_block_last;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = tpsd_pkg::CFG_BIT_ORDER;
  logic [63:0] cfg_wdata = '0;

  tape_pulse_sync_and_byte_decoder_unit u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_pulse_class       (in_pulse_class),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_event_kind       (out_event_kind),
    .out_data_value       (out_data_value),
    .out_byte_index       (out_byte_index),
    .out_running_checksum (out_running_checksum),
    .out_checksum_ok      (out_checksum_ok),
    .out_block_last       (out_block_last),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // decoder model state and register copy
  tpsd_pkg::cfg_t   cfg;
  tpsd_pkg::phase_t ph;
  logic [7:0]  shreg;
  int          nbits;
  int          pmatch;
  int          prun;
  int          sidx;
  logic [7:0]  csum;
  logic [15:0] dcount;

  logic [1:0]        tape_pulses[$];
  tpsd_pkg::result_t events_due[$];
  tpsd_pkg::result_t next_event;
  tpsd_pkg::result_t seen;
  tpsd_pkg::result_t want;
  int          queued_pulses = 0;
  int          cut_left = -1;
  int          fail_count = 0;
  int          cycle_count = 0;
  int          send_gap = 0;
  int          recv_gap = 0;
  bit          steady = 1'b0;

  function automatic void clear_search();
    ph = tpsd_pkg::PH_HUNT;
    shreg = '0;
    nbits = 0;
    pmatch = 0;
    prun = 0;
    sidx = 0;
    csum = '0;
    dcount = '0;
  endfunction

  function automatic void start_data();
    ph = tpsd_pkg::PH_DATA;
    nbits = 0;
    csum = '0;
    dcount = '0;
  endfunction

  function automatic void shift_bit(input logic b);
    if (cfg.bit_order) shreg = {shreg[6:0], b};
    else shreg = {b, shreg[7:1]};
  endfunction

  function automatic int sync_len();
    return (cfg.sync_length > SYNC_MAX) ? SYNC_MAX : int'(cfg.sync_length);
  endfunction

  function automatic tpsd_pkg::result_t make_event(input logic [1:0] kind,
                                                   input logic [7:0] value,
                                                   input logic [15:0] index,
                                                   input logic [7:0] sum,
                                                   input logic ok, input logic last);
    tpsd_pkg::result_t r;
    r.event_kind = kind;
    r.data_value = value;
    r.byte_index = index;
    r.running_checksum = sum;
    r.checksum_ok = ok;
    r.block_last = last;
    return r;
  endfunction

  function automatic bit take_sync_byte(output tpsd_pkg::result_t res);
    int len;
    int k;
    len = sync_len();
    k = sidx & 7;
    if (len != 0) begin
      if (shreg != cfg.sync_bytes[8*k +: 8]) begin
        clear_search();
        return 1'b0;
      end
      sidx = k + 1;
      if (sidx < len) begin
        ph = tpsd_pkg::PH_SYNC;
        nbits = 0;
        return 1'b0;
      end
    end
    res = make_event(tpsd_pkg::EV_SYNC, shreg, '0, '0, 1'b0, 1'b0);
    start_data();
    return 1'b1;
  endfunction

  function automatic bit decode_pulse(input logic [1:0] cls, output tpsd_pkg::result_t res);
    logic        b;
    int          len;
    bit          chk;
    bit          done;
    logic [15:0] idx;
    b = cls[0];
    if (ph == tpsd_pkg::PH_HUNT && (cfg.pilot_mode == tpsd_pkg::PM_NONE ||
        cfg.pilot_mode == tpsd_pkg::PM_BYTE) && sync_len() == 0)
      start_data();
    else if (ph == tpsd_pkg::PH_HUNT && cfg.pilot_mode == tpsd_pkg::PM_NONE)
      ph = tpsd_pkg::PH_SYNC;
    if (cls != tpsd_pkg::PC_ZERO && cls != tpsd_pkg::PC_ONE) begin
      if (ph == tpsd_pkg::PH_DATA || ph == tpsd_pkg::PH_CHECK) begin
        res = make_event(tpsd_pkg::EV_ABORT, '0, dcount, csum, 1'b0, 1'b1);
        clear_search();
        return 1'b1;
      end
      clear_search();
      return 1'b0;
    end
    case (ph)
      tpsd_pkg::PH_HUNT: begin
        if (cfg.pilot_mode == tpsd_pkg::PM_BYTE) begin
          shift_bit(b);
          if (shreg == cfg.pilot_value) begin
            pmatch++;
            if (pmatch >= int'(tpsd_pkg::PILOT_LOCK_MATCHES)) begin
              pmatch = int'(tpsd_pkg::PILOT_LOCK_MATCHES);
              ph = tpsd_pkg::PH_PILOT_BYTES;
              nbits = 0;
              prun = 0;
            end
          end
          return 1'b0;
        end
        if (b != ((cfg.pilot_mode == tpsd_pkg::PM_ONES) ? 1'b0 : 1'b1)) begin
          if (prun < int'(tpsd_pkg::RUN_COUNT_MAX)) prun++;
          return 1'b0;
        end
        if (prun < int'(cfg.min_pilot_count)) begin
          clear_search();
          return 1'b0;
        end
        sidx = 0;
        if (sync_len() == 0) begin
          res = make_event(tpsd_pkg::EV_SYNC, '0, '0, '0, 1'b0, 1'b0);
          start_data();
          return 1'b1;
        end
        ph = tpsd_pkg::PH_SYNC;
        nbits = 0;
        shreg = '0;
        return 1'b0;
      end
      tpsd_pkg::PH_PILOT_BYTES: begin
        shift_bit(b);
        nbits++;
        if (nbits < 8) return 1'b0;
        nbits = 0;
        if (prun < int'(tpsd_pkg::RUN_COUNT_MAX)) prun++;
        if (shreg == cfg.pilot_value) return 1'b0;
        if (prun < int'(cfg.min_pilot_count)) begin
          ph = tpsd_pkg::PH_HUNT;
          pmatch = 0;
          prun = 0;
          return 1'b0;
        end
        sidx = 0;
        return take_sync_byte(res);
      end
      tpsd_pkg::PH_SYNC: begin
        shift_bit(b);
        nbits++;
        if (nbits < 8) return 1'b0;
        nbits = 0;
        return take_sync_byte(res);
      end
      tpsd_pkg::PH_DATA: begin
        len = (cfg.data_length == 0) ? 1 : int'(cfg.data_length);
        chk = (cfg.checksum_mode == tpsd_pkg::CM_ADD_CHECK ||
               cfg.checksum_mode == tpsd_pkg::CM_XOR_CHECK);
        shift_bit(b);
        nbits++;
        if (nbits < 8) return 1'b0;
        nbits = 0;
        if (cfg.checksum_mode == tpsd_pkg::CM_ADD ||
            cfg.checksum_mode == tpsd_pkg::CM_ADD_CHECK)
          csum = csum + shreg;
        else if (cfg.checksum_mode == tpsd_pkg::CM_XOR ||
                 cfg.checksum_mode == tpsd_pkg::CM_XOR_CHECK)
          csum = csum ^ shreg;
        idx = dcount;
        dcount = dcount + 16'd1;
        done = (int'(idx) + 1) >= len;
        res = make_event(tpsd_pkg::EV_DATA, shreg, idx, csum, 1'b0, done && !chk);
        if (done) begin
          if (chk) begin
            ph = tpsd_pkg::PH_CHECK;
            nbits = 0;
          end else begin
            clear_search();
          end
        end
        return 1'b1;
      end
      tpsd_pkg::PH_CHECK: begin
        shift_bit(b);
        nbits++;
        if (nbits < 8) return 1'b0;
        res = make_event(tpsd_pkg::EV_CHECK, shreg, dcount, csum, shreg == csum, 1'b1);
        clear_search();
        return 1'b1;
      end
      default: begin
        clear_search();
        return 1'b0;
      end
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // driver: one pulse per transfer, predict on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_pulse_class <= tpsd_pkg::PC_ZERO;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        if (decode_pulse(in_pulse_class, next_event)) events_due.push_back(next_event);
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (tape_pulses.size() != 0) begin
          in_valid <= 1'b1;
          in_pulse_class <= tape_pulses.pop_front();
          send_gap <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each transfer with the oldest expected event
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (out_valid && out_ready) begin
        seen = make_event(out_event_kind, out_data_value, out_byte_index,
                          out_running_checksum, out_checksum_ok, out_block_last);
        if (events_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected event: kind %0d value %02h index %0d sum %02h ok %0b last %0b",
                     seen.event_kind, seen.data_value, seen.byte_index,
                     seen.running_checksum, seen.checksum_ok, seen.block_last);
        end else begin
          want = events_due.pop_front();
          if (seen.event_kind !== want.event_kind || seen.data_value !== want.data_value ||
              seen.byte_index !== want.byte_index ||
              seen.running_checksum !== want.running_checksum ||
              seen.checksum_ok !== want.checksum_ok || seen.block_last !== want.block_last) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("mismatch: exp kind %0d value %02h index %0d sum %02h ok %0b last %0b",
                       want.event_kind, want.data_value, want.byte_index,
                       want.running_checksum, want.checksum_ok, want.block_last);
              $display("          got kind %0d value %02h index %0d sum %02h ok %0b last %0b",
                       seen.event_kind, seen.data_value, seen.byte_index,
                       seen.running_checksum, seen.checksum_ok, seen.block_last);
            end
          end
        end
      end
      if (recv_gap > 0) begin
        out_ready <= 1'b0;
        recv_gap <= recv_gap - 1;
      end else begin
        out_ready <= 1'b1;
        if (out_valid && out_ready) recv_gap <= pick_gap();
        else if ($urandom_range(0, 15) == 0) recv_gap <= pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tape_pulse_sync_and_byte_decoder_unit test failed");
      $finish;
    end
  end

  function automatic void put_pulse(input logic [1:0] cls);
    tape_pulses.push_back(cls);
    queued_pulses++;
  endfunction

  // at the cut point put one invalid pulse, then drop the rest of the block
  function automatic void put_bit(input logic b);
    if (cut_left < -1) return;
    if (cut_left == 0) begin
      put_pulse($urandom_range(0, 1) ? PC_INVALID : PC_INVALID_HI);
      cut_left = -2;
      return;
    end
    if (cut_left > 0) cut_left--;
    put_pulse(b ? tpsd_pkg::PC_ONE : tpsd_pkg::PC_ZERO);
  endfunction

  function automatic void put_byte(input logic [7:0] v);
    for (int i = 0; i < 8; i++) put_bit(cfg.bit_order ? v[7-i] : v[i]);
  endfunction

  function automatic void queue_block();
    int         r;
    int         n;
    int         len;
    int         dl;
    bit         chk;
    bit         forced;
    logic [7:0] v;
    logic [7:0] sum;
    r = $urandom_range(0, 99);
    cut_left = -1;
    if (r < 8) begin
      n = $urandom_range(4, 40);
      repeat (n) begin
        if ($urandom_range(0, 9) == 0)
          put_pulse($urandom_range(0, 1) ? PC_INVALID : PC_INVALID_HI);
        else
          put_pulse($urandom_range(0, 1) ? tpsd_pkg::PC_ONE : tpsd_pkg::PC_ZERO);
      end
      return;
    end
    len = sync_len();
    chk = (cfg.checksum_mode == tpsd_pkg::CM_ADD_CHECK ||
           cfg.checksum_mode == tpsd_pkg::CM_XOR_CHECK);
    dl = (cfg.data_length == 0) ? 1 : int'(cfg.data_length);
    forced = (dl > 24);
    if (forced) dl = $urandom_range(1, 5);
    case (cfg.pilot_mode)
      tpsd_pkg::PM_BYTE: begin
        if (len != 0) begin
          if (cfg.min_pilot_count > 40) n = 8 + $urandom_range(0, 3);
          else if (r < 14 && cfg.min_pilot_count >= 2) n = 6 + int'(cfg.min_pilot_count);
          else n = 8 + int'(cfg.min_pilot_count) + $urandom_range(0, 2);
          repeat (n) put_byte(cfg.pilot_value);
        end
      end
      tpsd_pkg::PM_ONES, tpsd_pkg::PM_ZEROS: begin
        if (cfg.min_pilot_count > 200) n = $urandom_range(1, 40);
        else if (r < 14 && cfg.min_pilot_count > 0) n = int'(cfg.min_pilot_count) - 1;
        else n = int'(cfg.min_pilot_count) + $urandom_range(0, 5);
        repeat (n) put_bit(cfg.pilot_mode == tpsd_pkg::PM_ONES);
        put_bit(cfg.pilot_mode != tpsd_pkg::PM_ONES);
      end
      default: ;
    endcase
    n = (r >= 14 && r < 20 && len != 0) ? $urandom_range(0, len - 1) : -1;
    for (int k = 0; k < len; k++) begin
      v = cfg.sync_bytes[8*k +: 8];
      if (k == n) v = v ^ (8'd1 << $urandom_range(0, 7));
      put_byte(v);
    end
    if (forced || (r >= 20 && r < 32))
      cut_left = $urandom_range(0, 8 * dl + (chk ? 8 : 0) - 1);
    sum = '0;
    for (int i = 0; i < dl; i++) begin
      case ($urandom_range(0, 9))
        0:       v = 8'h00;
        1:       v = 8'hFF;
        default: v = 8'($urandom_range(0, 255));
      endcase
      if (cfg.checksum_mode == tpsd_pkg::CM_ADD ||
          cfg.checksum_mode == tpsd_pkg::CM_ADD_CHECK) sum = sum + v;
      else if (cfg.checksum_mode == tpsd_pkg::CM_XOR ||
               cfg.checksum_mode == tpsd_pkg::CM_XOR_CHECK) sum = sum ^ v;
      put_byte(v);
    end
    if (chk) put_byte(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : sum);
    cut_left = -1;
  endfunction

  task automatic wait_idle();
    while (tape_pulses.size() != 0 || in_valid || events_due.size() != 0) @(negedge clk);
  endtask

  task automatic settle();
    wait_idle();
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
  endtask

  task automatic load_settings(input int p);
    tpsd_pkg::cfg_t c;
    c.bit_order = 1'($urandom_range(0, 1));
    c.pilot_mode = 2'($urandom_range(0, 3));
    case ($urandom_range(0, 7))
      0:       c.pilot_value = 8'h00;
      1:       c.pilot_value = 8'hFF;
      default: c.pilot_value = 8'($urandom_range(0, 255));
    endcase
    case ($urandom_range(0, 19))
      0:       c.min_pilot_count = 16'hFFFF;
      1:       c.min_pilot_count = 16'($urandom_range(0, 65535));
      default: c.min_pilot_count = (c.pilot_mode == tpsd_pkg::PM_BYTE) ?
                                   16'($urandom_range(0, 4)) : 16'($urandom_range(0, 30));
    endcase
    c.sync_length = ($urandom_range(0, 99) < 15) ? 4'($urandom_range(9, 15))
                                                 : 4'($urandom_range(0, 8));
    c.sync_bytes = {$urandom(), $urandom()};
    c.checksum_mode = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(0, 4))
                                                   : 3'($urandom_range(5, 7));
    case ($urandom_range(0, 19))
      0:       c.data_length = 16'hFFFF;
      1, 2:    c.data_length = 16'($urandom_range(7, 20));
      default: c.data_length = 16'($urandom_range(0, 6));
    endcase
    if (p == 1) begin
      c.pilot_mode = tpsd_pkg::PM_BYTE;
      c.pilot_value = 8'h00;
      c.min_pilot_count = '0;
      c.sync_length = 4'hF;
      c.sync_bytes = '1;
      c.checksum_mode = 3'h7;
      c.data_length = 16'hFFFF;
    end else if (p == 2) begin
      c.bit_order = 1'b1;
      c.pilot_mode = tpsd_pkg::PM_ONES;
      c.pilot_value = 8'hFF;
      c.min_pilot_count = 16'hFFFF;
      c.sync_length = '0;
      c.sync_bytes = '0;
      c.checksum_mode = tpsd_pkg::CM_XOR_CHECK;
      c.data_length = '0;
    end
    write_reg(tpsd_pkg::CFG_BIT_ORDER, 64'(c.bit_order));
    write_reg(tpsd_pkg::CFG_PILOT_MODE, 64'(c.pilot_mode));
    write_reg(tpsd_pkg::CFG_PILOT_VALUE, 64'(c.pilot_value));
    write_reg(tpsd_pkg::CFG_MIN_PILOT_COUNT, 64'(c.min_pilot_count));
    write_reg(tpsd_pkg::CFG_SYNC_LENGTH, 64'(c.sync_length));
    write_reg(tpsd_pkg::CFG_SYNC_BYTES, c.sync_bytes);
    write_reg(tpsd_pkg::CFG_CHECKSUM_MODE, 64'(c.checksum_mode));
    write_reg(tpsd_pkg::CFG_DATA_LENGTH, 64'(c.data_length));
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg = c;
    @(negedge clk);
  endtask

  initial begin
    int nblk;
    int phase_no;
    cfg.bit_order = 1'b0;
    cfg.pilot_mode = tpsd_pkg::PM_BYTE;
    cfg.pilot_value = '0;
    cfg.min_pilot_count = '0;
    cfg.sync_length = '0;
    cfg.sync_bytes = '0;
    cfg.checksum_mode = tpsd_pkg::CM_NONE;
    cfg.data_length = 16'd1;
    clear_search();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: data starts at once, invalid pulses abort even before a bit
    put_byte(8'hA5);
    put_pulse(PC_INVALID);
    put_pulse(PC_INVALID_HI);
    put_bit(1'b1);
    put_bit(1'b1);
    put_bit(1'b0);
    put_pulse(PC_INVALID_HI);
    put_byte(8'h5A);
    settle();

    phase_no = 0;
    while (queued_pulses < PULSE_TARGET) begin
      load_settings(phase_no);
      nblk = $urandom_range(3, 8);
      for (int i = 0; i < nblk && queued_pulses < PULSE_TARGET; i++) begin
        steady = ($urandom_range(0, 4) == 0);
        queue_block();
        if (i == 0 && phase_no % 3 == 0) wait_idle();
      end
      put_pulse(PC_INVALID);
      settle();
      phase_no++;
    end

    settle();
    if (fail_count == 0 && events_due.size() == 0)
      $display("tape_pulse_sync_and_byte_decoder_unit test passed");
    else
      $display("tape_pulse_sync_and_byte_decoder_unit test failed");
    $finish;
  end

endmodule
